>>> rtl/rcm_pkg.sv
package rcm_pkg;

  localparam int unsigned NumLetters = 26;
  localparam int unsigned NumTables  = 5;
  localparam int unsigned RotorTypes = 5;
  localparam int unsigned NumSlots   = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharLowA  = 8'd97;
  localparam logic [7:0] CharLowZ  = 8'd122;
  localparam logic [7:0] CharSpace = 8'd32;

  typedef logic [4:0] sym_t;
  typedef sym_t [NumLetters-1:0] perm_t;
  typedef logic [2:0] rotor_sel_t;

  localparam rotor_sel_t LastRotor =
    rotor_sel_t'(((RotorTypes < NumTables) ? RotorTypes : NumTables) - 1);
  localparam sym_t LastSym = sym_t'(NumLetters - 1);

  typedef enum logic [2:0] {
    CfgDecodeMode  = 3'd0,
    CfgPlugAtoL    = 3'd1,
    CfgPlugMtoX    = 3'd2,
    CfgPlugYZ      = 3'd3,
    CfgRotorChoice = 3'd4,
    CfgStartPos    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                          decode;
    perm_t                         plug;
    rotor_sel_t [NumSlots-1:0]     rotor;
  } cfg_t;

  typedef struct packed {
    logic                    letter;
    sym_t                    sym;
    sym_t [NumSlots-1:0]     pos;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic perm_t str_to_perm(input logic [8*NumLetters-1:0] s);
    perm_t p;
    for (int i = 0; i < NumLetters; i++) begin
      p[i] = sym_t'(s[8*(NumLetters-1-i) +: 8] - CharLowA);
    end
    return p;
  endfunction

  function automatic perm_t invert(input perm_t p);
    perm_t q;
    q = '0;
    for (int i = 0; i < NumLetters; i++) begin
      q[p[i]] = sym_t'(i);
    end
    return q;
  endfunction

  localparam perm_t FwdTab [NumTables] = '{
    str_to_perm("tcgjzfwbpdrvyxemhasuqilkon"),
    str_to_perm("rlsqgwdmkajhponiyvxecfbtuz"),
    str_to_perm("okpavscexrqjimbzgtdwfunlhy"),
    str_to_perm("bunztilgyvfokrhapqcmdjwexs"),
    str_to_perm("yewhonxlusdctqvjkzbfrpaigm")
  };
  localparam perm_t InvTab [NumTables] = '{
    invert(FwdTab[0]), invert(FwdTab[1]), invert(FwdTab[2]),
    invert(FwdTab[3]), invert(FwdTab[4])
  };
  localparam perm_t ReflTab = str_to_perm("lagpsejfztmqdoyvixkhwcrbnu");
  localparam perm_t InvRefl = invert(ReflTab);

  function automatic sym_t clamp_sym(input logic [4:0] v);
    return (v > LastSym) ? LastSym : v;
  endfunction

  function automatic rotor_sel_t clamp_rotor(input rotor_sel_t r);
    return (r > LastRotor) ? LastRotor : r;
  endfunction

  function automatic sym_t add_mod(input sym_t a, input sym_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 6'(NumLetters)) ? sym_t'(s - 6'(NumLetters)) : sym_t'(s);
  endfunction

  function automatic sym_t sub_mod(input sym_t a, input sym_t b);
    logic [5:0] s;
    s = {1'b0, a} + 6'(NumLetters) - {1'b0, b};
    return (a >= b) ? sym_t'(a - b) : sym_t'(s);
  endfunction

  function automatic sym_t rotor_pass(input sym_t c, input sym_t pos,
                                      input rotor_sel_t r, input logic dec);
    return dec ? sub_mod(InvTab[r][c], pos) : FwdTab[r][add_mod(c, pos)];
  endfunction

  function automatic sym_t reflect(input sym_t c, input logic dec);
    return dec ? InvRefl[c] : ReflTab[c];
  endfunction

endpackage

>>> rtl/rcm_channels.sv
interface rcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       new_message;

  modport source (output valid, output char_in, output new_message, input ready);
  modport sink   (input valid, input char_in, input new_message, output ready);
endinterface

interface rcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

interface rcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [59:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/rcm_front.sv
module rcm_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  rcm_in_if.sink                                 in_i,
  input  rcm_pkg::sym_t [rcm_pkg::NumSlots-1:0]  start_i,
  input  logic                                   q_full_i,
  output logic                                   push_o,
  output rcm_pkg::item_t                         item_o
);
  import rcm_pkg::*;

  sym_t [NumSlots-1:0] pos_q, pos_d;
  sym_t [NumSlots-1:0] base, stepped;
  logic                letter;
  logic                accept;
  logic                carry0, carry1;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  always_comb begin
    letter  = (in_i.char_in >= CharLowA) && (in_i.char_in <= CharLowZ);
    base    = in_i.new_message ? start_i : pos_q;
    // odometer, slot 0 fastest
    carry0  = (base[0] == LastSym);
    carry1  = carry0 && (base[1] == LastSym);
    stepped[0] = carry0 ? '0 : base[0] + sym_t'(1);
    stepped[1] = carry0 ? (base[1] == LastSym ? '0 : base[1] + sym_t'(1)) : base[1];
    stepped[2] = carry1 ? (base[2] == LastSym ? '0 : base[2] + sym_t'(1)) : base[2];

    pos_d = pos_q;
    if (accept) begin
      pos_d = letter ? stepped : base;
    end

    item_o.letter = letter;
    item_o.sym    = sym_t'(in_i.char_in - CharLowA);
    item_o.pos    = base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

>>> rtl/rcm_queue.sv
module rcm_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rcm_pkg::item_t       item_i,
  input  logic                 pop_i,
  output rcm_pkg::item_t       item_o,
  output rcm_pkg::q_status_t   status_o
);
  import rcm_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t             mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign status_o.full  = (count_q == CntW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign item_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/rcm_back.sv
module rcm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rcm_pkg::cfg_t        cfg_i,
  input  rcm_pkg::item_t       item_i,
  input  rcm_pkg::q_status_t   q_status_i,
  output logic                 pop_o,
  rcm_out_if.source            out_o
);
  import rcm_pkg::*;

  logic                s1_valid_q, s2_valid_q, out_valid_q;
  logic                s1_letter_q, s2_letter_q;
  sym_t                s1_sym_q, s1_sym_d;
  sym_t                s2_sym_q, s2_sym_d;
  sym_t [NumSlots-1:0] s1_pos_q;
  sym_t [NumSlots-1:0] s2_pos_q;
  logic [7:0]          char_q, char_d;
  logic                adv;
  sym_t                t0, t1, t2, t3, t4, t5;

  // whole pipeline moves unless a result is held by the sink
  assign adv         = !out_valid_q || out_o.ready;
  assign pop_o       = adv && !q_status_i.empty;
  assign out_o.valid = out_valid_q;
  assign out_o.char_out = char_q;

  always_comb begin
    // plugboard and the first two rotor slots
    t0       = cfg_i.plug[clamp_sym(item_i.sym)];
    t1       = rotor_pass(t0, item_i.pos[0], cfg_i.rotor[0], cfg_i.decode);
    s1_sym_d = rotor_pass(t1, item_i.pos[1], cfg_i.rotor[1], cfg_i.decode);

    // last slot, reflector, back through the last slot
    t2       = rotor_pass(s1_sym_q, s1_pos_q[2], cfg_i.rotor[2], cfg_i.decode);
    t3       = reflect(t2, cfg_i.decode);
    s2_sym_d = rotor_pass(t3, s1_pos_q[2], cfg_i.rotor[2], cfg_i.decode);

    // back through slots 1 and 0, then the plugboard
    t4     = rotor_pass(s2_sym_q, s2_pos_q[1], cfg_i.rotor[1], cfg_i.decode);
    t5     = rotor_pass(t4, s2_pos_q[0], cfg_i.rotor[0], cfg_i.decode);
    char_d = s2_letter_q ? (8'(cfg_i.plug[t5]) + CharLowA) : CharSpace;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_status_i.empty;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_letter_q <= item_i.letter;
      s1_sym_q    <= s1_sym_d;
      s1_pos_q    <= item_i.pos;
      s2_letter_q <= s1_letter_q;
      s2_sym_q    <= s2_sym_d;
      s2_pos_q    <= s1_pos_q;
      char_q      <= char_d;
    end
  end

endmodule

>>> rtl/rotor_cipher_machine_unit.sv
// Three-slot rotor substitution cipher on a byte stream. One character is taken
// per cycle while the queue has room, one result byte comes out for each, in
// order; lowercase letters are substituted and step the rotor positions as a
// base-26 odometer (slot 0 fastest), other bytes come back as a space without
// stepping. new_message reloads the start positions ahead of its character. A
// taken character goes through a two-entry queue and then a three-stage lookup
// pipeline (s1, s2, output register); the block sustains one character per cycle
// while the sink keeps up. Configuration must be written through the cfg port
// only while no characters are in flight; the block does not enforce this.
module rotor_cipher_machine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcm_in_if.sink      in_i,
  rcm_out_if.source   out_o,
  rcm_cfg_if.sink     cfg_i
);
  import rcm_pkg::*;

  logic                decode_q;
  logic [59:0]         plug_al_q;
  logic [59:0]         plug_mx_q;
  logic [9:0]          plug_yz_q;
  logic [8:0]          rotor_choice_q;
  logic [14:0]         start_q;
  cfg_t                cfg;
  sym_t [NumSlots-1:0] start_pos;
  logic                push, pop;
  item_t               push_item, pop_item;
  q_status_t           q_status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q       <= 1'b0;
      plug_al_q      <= 60'd407901468851537952;
      plug_mx_q      <= 60'd854193664183220652;
      plug_yz_q      <= 10'd824;
      rotor_choice_q <= 9'd136;
      start_q        <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CfgDecodeMode:  decode_q       <= cfg_i.data[0];
        CfgPlugAtoL:    plug_al_q      <= cfg_i.data;
        CfgPlugMtoX:    plug_mx_q      <= cfg_i.data;
        CfgPlugYZ:      plug_yz_q      <= cfg_i.data[9:0];
        CfgRotorChoice: rotor_choice_q <= cfg_i.data[8:0];
        CfgStartPos:    start_q        <= cfg_i.data[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.decode = decode_q;
    for (int i = 0; i < 12; i++) begin
      cfg.plug[i]      = clamp_sym(plug_al_q[5*i +: 5]);
      cfg.plug[i + 12] = clamp_sym(plug_mx_q[5*i +: 5]);
    end
    cfg.plug[24] = clamp_sym(plug_yz_q[4:0]);
    cfg.plug[25] = clamp_sym(plug_yz_q[9:5]);
    for (int s = 0; s < NumSlots; s++) begin
      cfg.rotor[s] = clamp_rotor(rotor_choice_q[3*s +: 3]);
      start_pos[s] = clamp_sym(start_q[5*s +: 5]);
    end
  end

  rcm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .start_i  (start_pos),
    .q_full_i (q_status.full),
    .push_o   (push),
    .item_o   (push_item)
  );

  rcm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  rcm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_i     (pop_item),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // results are always a space or a lowercase letter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_out == CharSpace) ||
                    ((out_o.char_out >= CharLowA) && (out_o.char_out <= CharLowZ)))
    else $error("result byte outside the output alphabet");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // a transaction taken while the queue is empty is in the queue next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && q_status.empty) |=> !q_status.empty)
    else $error("accepted character lost before the queue");

endmodule

>>> tb/tb_rotor_cipher_machine_unit.sv
`timescale 1ns / 1ps

module tb_rotor_cipher_machine_unit;
  import rcm_pkg::*;

  localparam logic [2:0] CfgSpareLo = 3'd6;
  localparam logic [2:0] CfgSpareHi = 3'd7;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned SettleCycles = 8;

  logic clk;
  logic rst_n;

  rcm_in_if  in_ch ();
  rcm_out_if out_ch ();
  rcm_cfg_if cfg_ch ();

  rotor_cipher_machine_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // rotor wirings, built from the letter strings at time zero
  logic [4:0] fwd_wire [NumTables][NumLetters];
  logic [4:0] inv_wire [NumTables][NumLetters];
  logic [4:0] refl_wire [NumLetters];
  logic [4:0] inv_refl_wire [NumLetters];

  // shadow of the cipher settings and rotor state
  logic        m_decode;
  logic [59:0] m_plug_al;
  logic [59:0] m_plug_mx;
  logic [9:0]  m_plug_yz;
  logic [8:0]  m_rotors;
  logic [14:0] m_start;
  logic [4:0]  m_pos [NumSlots];

  logic [7:0] expected_chars [$];
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned hold_left;
  int unsigned stall_cycles;
  int unsigned fail_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic string wiring_text(input int t);
    case (t)
      0: return "tcgjzfwbpdrvyxemhasuqilkon";
      1: return "rlsqgwdmkajhponiyvxecfbtuz";
      2: return "okpavscexrqjimbzgtdwfunlhy";
      3: return "bunztilgyvfokrhapqcmdjwexs";
      default: return "yewhonxlusdctqvjkzbfrpaigm";
    endcase
  endfunction

  task automatic build_wiring();
    string w;
    logic [7:0] b;
    for (int t = 0; t < NumTables; t++) begin
      w = wiring_text(t);
      for (int i = 0; i < NumLetters; i++) begin
        b = w[i] - CharLowA;
        fwd_wire[t][i] = b[4:0];
        inv_wire[t][b[4:0]] = i[4:0];
      end
    end
    w = "lagpsejfztmqdoyvixkhwcrbnu";
    for (int i = 0; i < NumLetters; i++) begin
      b = w[i] - CharLowA;
      refl_wire[i] = b[4:0];
      inv_refl_wire[b[4:0]] = i[4:0];
    end
  endtask

  function automatic logic [4:0] clamp_letter(input logic [4:0] v);
    return (v > 5'd25) ? 5'd25 : v;
  endfunction

  function automatic int plug_through(input int k);
    logic [4:0] raw;
    if (k < 12) begin
      raw = m_plug_al[5*k +: 5];
    end else if (k < 24) begin
      raw = m_plug_mx[5*(k-12) +: 5];
    end else begin
      raw = m_plug_yz[5*(k-24) +: 5];
    end
    return int'(clamp_letter(raw));
  endfunction

  function automatic int rotor_sel(input int s);
    logic [2:0] r;
    r = m_rotors[3*s +: 3];
    return (r > 3'd4) ? 4 : int'(r);
  endfunction

  function automatic int rotor_step(input int c, input int s);
    if (m_decode) begin
      return (int'(inv_wire[rotor_sel(s)][c]) + NumLetters - int'(m_pos[s])) % NumLetters;
    end
    return int'(fwd_wire[rotor_sel(s)][(c + int'(m_pos[s])) % NumLetters]);
  endfunction

  // substitutes one character and, for a letter, advances the rotor odometer
  function automatic logic [7:0] cipher_char(input logic [7:0] ch, input logic nm);
    int c;
    logic [7:0] res;
    if (nm) begin
      for (int s = 0; s < NumSlots; s++) m_pos[s] = clamp_letter(m_start[5*s +: 5]);
    end
    if (ch < CharLowA || ch > CharLowZ) return CharSpace;
    c = plug_through(int'(ch - CharLowA));
    for (int s = 0; s < NumSlots; s++) c = rotor_step(c, s);
    c = m_decode ? int'(inv_refl_wire[c]) : int'(refl_wire[c]);
    for (int s = NumSlots - 1; s >= 0; s--) c = rotor_step(c, s);
    c = plug_through(c);
    res = CharLowA + c[7:0];
    m_pos[0] = 5'((m_pos[0] + 1) % NumLetters);
    if (m_pos[0] == 0) begin
      m_pos[1] = 5'((m_pos[1] + 1) % NumLetters);
      if (m_pos[1] == 0) m_pos[2] = 5'((m_pos[2] + 1) % NumLetters);
    end
    return res;
  endfunction

  function automatic logic [59:0] rand60();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[59:0];
  endfunction

  function automatic logic [7:0] rand_letter();
    return CharLowA + 8'($urandom_range(NumLetters - 1));
  endfunction

  function automatic logic [7:0] rand_non_letter();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b >= CharLowA && b <= CharLowZ) b = 8'($urandom_range(255));
    return b;
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic nm);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.char_in = ch;
    in_ch.new_message = nm;
    do @(posedge clk); while (!in_ch.ready);
    expected_chars.push_back(cipher_char(ch, nm));
  endtask

  task automatic wait_results();
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // stop the input stream and let the pipeline empty
  task automatic quiesce();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [59:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CfgDecodeMode:  m_decode = data[0];
      CfgPlugAtoL:    m_plug_al = data;
      CfgPlugMtoX:    m_plug_mx = data;
      CfgPlugYZ:      m_plug_yz = data[9:0];
      CfgRotorChoice: m_rotors = data[8:0];
      CfgStartPos:    m_start = data[14:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [59:0] pick_value();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return rand60();
    endcase
  endfunction

  task automatic configure_random();
    quiesce();
    write_reg(CfgDecodeMode, rand60());
    write_reg(CfgPlugAtoL, pick_value());
    write_reg(CfgPlugMtoX, pick_value());
    write_reg(CfgPlugYZ, pick_value());
    write_reg(CfgRotorChoice, pick_value());
    write_reg(CfgStartPos, pick_value());
    if ($urandom_range(3) == 0) write_reg($urandom_range(1) ? CfgSpareLo : CfgSpareHi, rand60());
  endtask

  // sends letters and non-letters under the reset-default settings
  task automatic test_reset_defaults();
    send_char(CharLowA, 1'b1);
    send_char(CharLowZ, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(CharLowA - 8'd1, 1'b0);
    send_char(CharLowZ + 8'd1, 1'b1);
    send_char(CharLowA + 8'd1, 1'b0);
  endtask

  task automatic test_clamping_and_wrap();
    quiesce();
    write_reg(CfgDecodeMode, 60'd0);
    write_reg(CfgPlugAtoL, '1);
    write_reg(CfgPlugMtoX, '0);
    write_reg(CfgPlugYZ, '1);
    write_reg(CfgRotorChoice, '1);
    write_reg(CfgStartPos, '1);
    // positions clamp to the last letter, so the first letter rolls all slots
    send_char(CharLowA, 1'b1);
    send_char(CharLowA + 8'd12, 1'b0);
    send_char(CharLowA + 8'd24, 1'b0);
    send_char(CharLowZ, 1'b0);
    quiesce();
    write_reg(CfgDecodeMode, 60'd1);
    write_reg(CfgRotorChoice, 60'd0);
    write_reg(CfgStartPos, 60'd0);
    write_reg(CfgPlugAtoL, 60'd0);
    send_char(CharLowA + 8'd23, 1'b1);
    send_char(CharLowA, 1'b0);
    send_char(8'h80, 1'b0);
    quiesce();
    write_reg(CfgSpareLo, '1);
    write_reg(CfgSpareHi, '1);
    send_char(CharLowA + 8'd16, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int unsigned n_items);
    int unsigned sent;
    int unsigned since_cfg;
    int unsigned len;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    sent = 0;
    since_cfg = 0;
    configure_random();
    while (sent < n_items) begin
      if (since_cfg > 60) begin
        configure_random();
        since_cfg = 0;
      end
      if ($urandom_range(9) < 8) begin
        // a message: reload then letters with the odd space or symbol
        len = $urandom_range(30, 1);
        for (int i = 0; i < len; i++) begin
          if (i != 0 && $urandom_range(9) == 0) begin
            send_char($urandom_range(1) ? CharSpace : rand_non_letter(), 1'b0);
          end else begin
            send_char(rand_letter(), i == 0);
          end
        end
      end else begin
        len = $urandom_range(5, 1);
        for (int i = 0; i < len; i++) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      sent += len;
      since_cfg += len;
    end
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    configure_random();
    hold_left = 120;
    for (int i = 0; i < 40; i++) send_char(rand_letter(), i == 0);
    // sender pauses until the pipeline has handed back everything
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait_results();
    for (int i = 0; i < 20; i++) send_char(rand_letter(), 1'b0);
  endtask

  // receiver: random ready, or a long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result transaction: char_out %0d", out_ch.char_out);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.char_out !== want) begin
          $error("char_out mismatch: expected %0d, actual %0d", want, out_ch.char_out);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_in = '0;
    in_ch.new_message = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    src_idle_pct = 34;
    sink_idle_pct = 78;
    hold_left = 0;
    stall_cycles = 0;
    fail_count = 0;
    m_decode = 1'b0;
    m_plug_al = 60'd407901468851537952;
    m_plug_mx = 60'd854193664183220652;
    m_plug_yz = 10'd824;
    m_rotors = 9'd136;
    m_start = '0;
    for (int s = 0; s < NumSlots; s++) m_pos[s] = '0;
    build_wiring();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_clamping_and_wrap();
    test_random_traffic(34, 78, 240);
    test_random_traffic(78, 34, 240);
    test_random_traffic(0, 0, 240);
    test_backpressure();

    quiesce();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
